// ----- hdl/rc4_stream_cipher_top_macros.svh -----
// ----------------------------------------------------------------------------
// RC4 engine assertion macros
// Shared concurrent assertion wrappers, clocked on clk, with or without a
// disable on rst.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// Checked only while rst is low.
`define RC4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, including the reset cycles.
`define RC4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// RC4 engine package
// Widths, request codes and shared types for the RC4 stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W          = 8;
  localparam int PERM_DEPTH      = 256;
  localparam int PERM_AW         = 8;
  localparam int KEY_MAX_DEFAULT = 256;

  typedef logic [BYTE_W-1:0] byte_t;

  // Request type codes.
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/rc4_if.sv -----
// ----------------------------------------------------------------------------
// RC4 engine channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_req_if import rc4_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  byte_t key_byte;
  logic  key_last;
  byte_t data_byte;
  logic  data_last;

  modport source (output valid, output req_type, output key_byte, output key_last,
                  output data_byte, output data_last, input ready);
  modport sink   (input valid, input req_type, input key_byte, input key_last,
                  input data_byte, input data_last, output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/rc4_ram.sv -----
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rc4_stream_cipher_top.sv -----
// ----------------------------------------------------------------------------
// RC4 stream cipher engine
// Key loading, 256-step key schedule and keystream generation around a
// permutation memory with one write port and one read port.
// ----------------------------------------------------------------------------
// How to use this block:
// Words arrive on the req channel and are taken when valid and ready are both
// high. A key word (req_type 0) stores key_byte; bytes past KEY_MAX are
// dropped. A key word with key_last set also runs the key schedule: 256
// steps, each through ST_K_RD, ST_K_J, ST_K_WN and ST_K_WJ, with ready low
// until the last step ends. The schedule always starts from the identity
// permutation and clears both indices and the key byte count when it ends.
// A data word (req_type 1) is served as two dependent reads of the
// permutation memory, then the two writes of the swap, with the keystream
// read overlapped with the first write. No new word is taken until the
// final write is done. The result word is registered on rsp in ST_D_OUT
// once the output register is free, and holds until rsp.ready is seen.
// A result waiting on a stalled receiver does not block the next request: it
// is accepted and processed, and only the final write of its swap waits for
// the output register to free up.
// Reset is synchronous. The permutation reads as identity right after reset
// through per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_top import rc4_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  rc4_req_if.sink    req,
  rc4_rsp_if.source  rsp
);

  // Key store addressing and key byte count widths follow KEY_MAX.
  localparam int KeyAw = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KcW   = $clog2(KEY_MAX + 1);
  localparam logic [KcW-1:0] KcMax = KcW'(KEY_MAX);

  // Sequencer states. The D states serve one data word, the K states one
  // step of the key schedule.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_D_J   = 8'b0000_0010,
    ST_D_T   = 8'b0000_0100,
    ST_D_OUT = 8'b0000_1000,
    ST_K_RD  = 8'b0001_0000,
    ST_K_J   = 8'b0010_0000,
    ST_K_WN  = 8'b0100_0000,
    ST_K_WJ  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Cipher state.
  byte_t            idx_i;
  byte_t            idx_j;
  logic [KcW-1:0]   key_count;
  byte_t            sched_n;
  logic [KeyAw-1:0] key_pos;

  // Swap operands and the data word being served.
  byte_t swap_a;
  byte_t swap_b;
  byte_t data_byte_q;
  logic  data_last_q;

  // Output register.
  logic  out_valid;
  byte_t out_byte;
  logic  out_last;

  // An entry whose valid bit is clear reads as its own address.
  logic [PERM_DEPTH-1:0] perm_vld;
  byte_t                 rd_addr_q;
  logic                  rd_vld_q;

  // Permutation memory port.
  logic  p_we;
  byte_t p_waddr;
  byte_t p_wdata;
  logic  p_re;
  byte_t p_raddr;
  byte_t perm_q;

  // Key store port.
  logic             k_we;
  logic [KeyAw-1:0] k_waddr;
  byte_t            k_wdata;
  logic             k_re;
  byte_t            key_q;

  // Datapath helpers.
  logic           req_fire;
  logic           out_free;
  logic           key_has_room;
  byte_t          perm_rd;
  byte_t          i_inc;
  byte_t          j_data;
  byte_t          j_key;
  byte_t          ks;
  logic [KcW-1:0] key_len;
  logic           key_wrap;

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.out_last = out_last;

  assign req_fire     = req.valid && req.ready;
  assign out_free     = !out_valid || rsp.ready;
  assign key_has_room = (key_count < KcMax);

  assign perm_rd = rd_vld_q ? perm_q : rd_addr_q;
  assign i_inc   = idx_i + 1'b1;
  assign j_data  = idx_j + perm_rd;
  assign j_key   = idx_j + perm_rd + key_q;

  // The keystream read overlaps the write of S[i]; the write of S[j] comes
  // after it, so both swapped entries are forwarded, S[j] taking priority.
  always_comb begin
    priority if (rd_addr_q == idx_j) begin
      ks = swap_a;
    end else if (rd_addr_q == idx_i) begin
      ks = swap_b;
    end else begin
      ks = perm_rd;
    end
  end

  // The key index wraps at the stored key length, at least one.
  assign key_len  = (key_count == '0) ? KcW'(1) : key_count;
  assign key_wrap = ((KcW'(key_pos) + KcW'(1)) >= key_len);

  always_comb begin
    state_next = state;
    p_we       = 1'b0;
    p_waddr    = '0;
    p_wdata    = '0;
    p_re       = 1'b0;
    p_raddr    = '0;
    k_we       = 1'b0;
    k_waddr    = key_count[KeyAw-1:0];
    k_wdata    = req.key_byte;
    k_re       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req.req_type == REQ_DATA) begin
            p_re       = 1'b1;
            p_raddr    = i_inc;
            state_next = ST_D_J;
          end else begin
            k_we = key_has_room;
            if (req.key_last) begin
              state_next = ST_K_RD;
            end
          end
        end
      end
      ST_D_J: begin
        p_re       = 1'b1;
        p_raddr    = j_data;
        state_next = ST_D_T;
      end
      ST_D_T: begin
        p_we       = 1'b1;
        p_waddr    = idx_i;
        p_wdata    = perm_rd;
        p_re       = 1'b1;
        p_raddr    = swap_a + perm_rd;
        state_next = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (out_free) begin
          p_we       = 1'b1;
          p_waddr    = idx_j;
          p_wdata    = swap_a;
          state_next = ST_IDLE;
        end
      end
      ST_K_RD: begin
        p_re       = 1'b1;
        p_raddr    = sched_n;
        k_re       = 1'b1;
        state_next = ST_K_J;
      end
      ST_K_J: begin
        p_re       = 1'b1;
        p_raddr    = j_key;
        state_next = ST_K_WN;
      end
      ST_K_WN: begin
        p_we       = 1'b1;
        p_waddr    = sched_n;
        p_wdata    = perm_rd;
        state_next = ST_K_WJ;
      end
      ST_K_WJ: begin
        p_we       = 1'b1;
        p_waddr    = idx_j;
        p_wdata    = swap_a;
        state_next = (sched_n == byte_t'(PERM_DEPTH - 1)) ? ST_IDLE : ST_K_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
      perm_vld  <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      state <= state_next;

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (p_we) begin
        perm_vld[p_waddr] <= 1'b1;
      end
      if (p_re) begin
        rd_addr_q <= p_raddr;
        rd_vld_q  <= perm_vld[p_raddr];
      end

      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.req_type == REQ_DATA) begin
              idx_i       <= i_inc;
              data_byte_q <= req.data_byte;
              data_last_q <= req.data_last;
            end else begin
              if (key_has_room) begin
                key_count <= key_count + 1'b1;
              end
              if (req.key_last) begin
                // The schedule restarts from the identity permutation.
                perm_vld <= '0;
                idx_j    <= '0;
                sched_n  <= '0;
                key_pos  <= '0;
              end
            end
          end
        end
        ST_D_J: begin
          swap_a <= perm_rd;
          idx_j  <= j_data;
        end
        ST_D_T: begin
          swap_b <= perm_rd;
        end
        ST_D_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= data_byte_q ^ ks;
            out_last  <= data_last_q;
          end
        end
        ST_K_RD: begin
        end
        ST_K_J: begin
          swap_a <= perm_rd;
          idx_j  <= j_key;
        end
        ST_K_WN: begin
        end
        ST_K_WJ: begin
          sched_n <= sched_n + 1'b1;
          key_pos <= key_wrap ? '0 : key_pos + 1'b1;
          if (sched_n == byte_t'(PERM_DEPTH - 1)) begin
            idx_i     <= '0;
            idx_j     <= '0;
            key_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (perm_q)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (key_pos),
    .rdata (key_q)
  );

endmodule

`default_nettype wire

// ----- hdl/rc4_checker.sv -----
// ----------------------------------------------------------------------------
// RC4 engine port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc4_stream_cipher_top_macros.svh"

module rc4_checker import rc4_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  req_valid,
  input logic  req_ready,
  input logic  req_type,
  input logic  rsp_valid,
  input logic  rsp_ready,
  input byte_t out_byte,
  input logic  out_last
);

  // A waiting result word is neither dropped nor changed.
  `RC4_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result word dropped while stalled")
  `RC4_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(out_byte) && $stable(out_last), "result word changed while stalled")

  // A data word keeps the engine busy for the cycles that follow.
  `RC4_ASSERT(a_data_busy, req_valid && req_ready && req_type == REQ_DATA |=> !req_ready, "ready high right after a data word")

  // Reset leaves an idle engine with no result pending.
  `RC4_ASSERT_ALWAYS(a_reset_idle, rst |=> req_ready && !rsp_valid, "engine not idle after reset")

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .out_byte  (rsp.out_byte),
  .out_last  (rsp.out_last)
);

`default_nettype wire
